FILE: hdl/rtch_pkg.sv
// Shared types, constants and the multiply-accumulate term table for the ray/triangle engine.
package rtch_pkg;

    localparam int COORD_W     = 32;
    localparam int VEC_W       = 33;
    localparam int PQ_W        = 67;
    localparam int DOT_W       = 101;
    localparam int ACC_W       = 136;
    localparam int QUO_W       = 34;
    localparam int INDEX_W     = 16;
    localparam int FACE_W      = 16;
    localparam int DIST_W      = 32;
    localparam int MUL_CNT_W   = $clog2(VEC_W);
    localparam int QCNT_W      = $clog2(QUO_W);
    localparam int TERM_W      = 5;
    localparam int CFG_INDEX_W = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [TERM_W-1:0] TERM_FIRST     = 5'd0;
    localparam logic [TERM_W-1:0] TERM_LAST_T    = 5'd23;
    localparam logic [TERM_W-1:0] TERM_NUM_FIRST = 5'd24;
    localparam logic [TERM_W-1:0] TERM_LAST      = 5'd26;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_DIR_X    = 3'd3,
        CFG_DIR_Y    = 3'd4,
        CFG_DIR_Z    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] v0_x;
        logic signed [COORD_W-1:0] v0_y;
        logic signed [COORD_W-1:0] v0_z;
        logic signed [COORD_W-1:0] v1_x;
        logic signed [COORD_W-1:0] v1_y;
        logic signed [COORD_W-1:0] v1_z;
        logic signed [COORD_W-1:0] v2_x;
        logic signed [COORD_W-1:0] v2_y;
        logic signed [COORD_W-1:0] v2_z;
        logic [FACE_W-1:0]         face_tag;
        logic                      last_tri;
    } tri_in_t;

    typedef struct packed {
        logic                      hit;
        logic [INDEX_W-1:0]        tri_index;
        logic [FACE_W-1:0]         face_id;
        logic [DIST_W-1:0]         distance;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } hit_out_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
    } ray_cfg_t;

    typedef logic signed [VEC_W-1:0] vec_t;

    typedef struct packed {
        vec_t [2:0]         e1;
        vec_t [2:0]         e2;
        vec_t [2:0]         s;
        logic [FACE_W-1:0]  face;
        logic [INDEX_W-1:0] index;
        logic               last;
    } tri_entry_t;

    typedef struct packed {
        logic               start;
        logic [ACC_W-1:0]   num;
        logic [DOT_W-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic               ovf;
        logic               rem_nz;
        logic [QUO_W-1:0]   quo;
    } div_res_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHECK,
        DV_RUN
    } div_state_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_LOAD,
        BK_MUL,
        BK_STORE,
        BK_FIX,
        BK_CHECK,
        BK_DIST,
        BK_DIST_WAIT,
        BK_PT_DIV,
        BK_PT_WAIT,
        BK_UPDATE,
        BK_END
    } back_state_t;

    typedef enum logic [2:0] {
        A_DIR,
        A_S,
        A_P,
        A_Q,
        A_T
    } a_src_t;

    typedef enum logic [1:0] {
        B_E1,
        B_E2,
        B_S,
        B_DIR
    } b_src_t;

    typedef enum logic [2:0] {
        D_NONE,
        D_P,
        D_DET,
        D_U,
        D_Q,
        D_V,
        D_T,
        D_NUM
    } dst_t;

    typedef struct packed {
        a_src_t     a_src;
        logic [1:0] a_idx;
        b_src_t     b_src;
        logic [1:0] b_idx;
        logic       sub;
        logic       first;
        dst_t       dst;
        logic [1:0] d_idx;
    } term_t;

    // Each term adds or subtracts one product; the last term of a sum names where it goes.
    function automatic term_t term_info(logic [TERM_W-1:0] k);
        term_t t;
        case (k)
            5'd0:  t = '{A_DIR, 2'd1, B_E2, 2'd2, 1'b0, 1'b1, D_NONE, 2'd0};
            5'd1:  t = '{A_DIR, 2'd2, B_E2, 2'd1, 1'b1, 1'b0, D_P,    2'd0};
            5'd2:  t = '{A_DIR, 2'd2, B_E2, 2'd0, 1'b0, 1'b1, D_NONE, 2'd0};
            5'd3:  t = '{A_DIR, 2'd0, B_E2, 2'd2, 1'b1, 1'b0, D_P,    2'd1};
            5'd4:  t = '{A_DIR, 2'd0, B_E2, 2'd1, 1'b0, 1'b1, D_NONE, 2'd0};
            5'd5:  t = '{A_DIR, 2'd1, B_E2, 2'd0, 1'b1, 1'b0, D_P,    2'd2};
            5'd6:  t = '{A_P,   2'd0, B_E1, 2'd0, 1'b0, 1'b1, D_NONE, 2'd0};
            5'd7:  t = '{A_P,   2'd1, B_E1, 2'd1, 1'b0, 1'b0, D_NONE, 2'd0};
            5'd8:  t = '{A_P,   2'd2, B_E1, 2'd2, 1'b0, 1'b0, D_DET,  2'd0};
            5'd9:  t = '{A_P,   2'd0, B_S,  2'd0, 1'b0, 1'b1, D_NONE, 2'd0};
            5'd10: t = '{A_P,   2'd1, B_S,  2'd1, 1'b0, 1'b0, D_NONE, 2'd0};
            5'd11: t = '{A_P,   2'd2, B_S,  2'd2, 1'b0, 1'b0, D_U,    2'd0};
            5'd12: t = '{A_S,   2'd1, B_E1, 2'd2, 1'b0, 1'b1, D_NONE, 2'd0};
            5'd13: t = '{A_S,   2'd2, B_E1, 2'd1, 1'b1, 1'b0, D_Q,    2'd0};
            5'd14: t = '{A_S,   2'd2, B_E1, 2'd0, 1'b0, 1'b1, D_NONE, 2'd0};
            5'd15: t = '{A_S,   2'd0, B_E1, 2'd2, 1'b1, 1'b0, D_Q,    2'd1};
            5'd16: t = '{A_S,   2'd0, B_E1, 2'd1, 1'b0, 1'b1, D_NONE, 2'd0};
            5'd17: t = '{A_S,   2'd1, B_E1, 2'd0, 1'b1, 1'b0, D_Q,    2'd2};
            5'd18: t = '{A_Q,   2'd0, B_DIR, 2'd0, 1'b0, 1'b1, D_NONE, 2'd0};
            5'd19: t = '{A_Q,   2'd1, B_DIR, 2'd1, 1'b0, 1'b0, D_NONE, 2'd0};
            5'd20: t = '{A_Q,   2'd2, B_DIR, 2'd2, 1'b0, 1'b0, D_V,    2'd0};
            5'd21: t = '{A_Q,   2'd0, B_E2, 2'd0, 1'b0, 1'b1, D_NONE, 2'd0};
            5'd22: t = '{A_Q,   2'd1, B_E2, 2'd1, 1'b0, 1'b0, D_NONE, 2'd0};
            5'd23: t = '{A_Q,   2'd2, B_E2, 2'd2, 1'b0, 1'b0, D_T,    2'd0};
            5'd24: t = '{A_T,   2'd0, B_DIR, 2'd0, 1'b0, 1'b1, D_NUM, 2'd0};
            5'd25: t = '{A_T,   2'd0, B_DIR, 2'd1, 1'b0, 1'b1, D_NUM, 2'd1};
            5'd26: t = '{A_T,   2'd0, B_DIR, 2'd2, 1'b0, 1'b1, D_NUM, 2'd2};
            default: t = '{A_DIR, 2'd0, B_E1, 2'd0, 1'b0, 1'b1, D_NONE, 2'd0};
        endcase
        return t;
    endfunction

endpackage

FILE: hdl/rtch_front.sv
// Front end: accepts triangles, numbers them and forms the edge and offset vectors.
module rtch_front
    import rtch_pkg::*;
#(
    parameter int MAX_TRIANGLES = 65536
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ray_cfg_t   cfg,
    input  logic       triangle_valid,
    output logic       triangle_stall,
    input  tri_in_t    triangle,
    input  logic       q_full,
    output logic       q_push,
    output tri_entry_t q_entry
);

    localparam int CNT_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam logic [CNT_W:0] CNT_LIMIT = (CNT_W + 1)'(MAX_TRIANGLES);

    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic [CNT_W:0]           cnt_inc;
    logic [INDEX_W+CNT_W-1:0] index_ext;
    logic                     accept;

    assign triangle_stall = q_full;
    assign accept         = triangle_valid && !q_full;
    assign q_push         = accept;

    assign cnt_inc   = {1'b0, cnt_reg} + (CNT_W + 1)'(1);
    assign index_ext = {{INDEX_W{1'b0}}, cnt_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (triangle.last_tri || (cnt_inc >= CNT_LIMIT))
            begin
                cnt_next = '0;
            end
            else
            begin
                cnt_next = cnt_inc[CNT_W-1:0];
            end
        end
    end

    always_comb
    begin
        q_entry.e1[0] = VEC_W'(triangle.v1_x) - VEC_W'(triangle.v0_x);
        q_entry.e1[1] = VEC_W'(triangle.v1_y) - VEC_W'(triangle.v0_y);
        q_entry.e1[2] = VEC_W'(triangle.v1_z) - VEC_W'(triangle.v0_z);
        q_entry.e2[0] = VEC_W'(triangle.v2_x) - VEC_W'(triangle.v0_x);
        q_entry.e2[1] = VEC_W'(triangle.v2_y) - VEC_W'(triangle.v0_y);
        q_entry.e2[2] = VEC_W'(triangle.v2_z) - VEC_W'(triangle.v0_z);
        q_entry.s[0]  = VEC_W'(cfg.origin_x) - VEC_W'(triangle.v0_x);
        q_entry.s[1]  = VEC_W'(cfg.origin_y) - VEC_W'(triangle.v0_y);
        q_entry.s[2]  = VEC_W'(cfg.origin_z) - VEC_W'(triangle.v0_z);
        q_entry.face  = triangle.face_tag;
        q_entry.index = index_ext[INDEX_W-1:0];
        q_entry.last  = triangle.last_tri;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: hdl/rtch_queue.sv
// Two-entry queue between the front end and the intersection engine.
module rtch_queue
    import rtch_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  tri_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       empty,
    output tri_entry_t head
);

    tri_entry_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;
    logic [QPTR_W:0]    count_next;

    assign full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: hdl/rtch_div.sv
// Serial restoring divider with a bounded quotient and an overflow flag.
module rtch_div
    import rtch_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_res_t res
);

    div_state_t         state_reg;
    div_state_t         state_next;
    logic [ACC_W-1:0]   rem_reg;
    logic [QUO_W-1:0]   low_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [DOT_W-1:0]   den_reg;
    logic [QCNT_W-1:0]  cnt_reg;
    logic               ovf_reg;
    logic               done_reg;
    logic [ACC_W-1:0]   rem_shift;
    logic               fits;
    logic               too_big;
    logic               last_step;
    logic               finish;

    assign rem_shift = {rem_reg[ACC_W-2:0], low_reg[QUO_W-1]};
    assign fits      = (rem_shift >= ACC_W'(den_reg));
    assign too_big   = (rem_reg >= ACC_W'(den_reg));
    assign last_step = (cnt_reg == QCNT_W'(QUO_W - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DV_IDLE:
            begin
                if (req.start)
                begin
                    state_next = DV_CHECK;
                end
            end
            DV_CHECK:
            begin
                state_next = too_big ? DV_IDLE : DV_RUN;
            end
            DV_RUN:
            begin
                if (last_step)
                begin
                    state_next = DV_IDLE;
                end
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            DV_CHECK: finish = too_big;
            DV_RUN:   finish = last_step;
            default:  finish = 1'b0;
        endcase
        res.done   = done_reg;
        res.ovf    = ovf_reg;
        res.rem_nz = (rem_reg != '0);
        res.quo    = quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
            if (state_reg == DV_RUN)
            begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            DV_IDLE:
            begin
                if (req.start)
                begin
                    rem_reg <= req.num >> QUO_W;
                    low_reg <= req.num[QUO_W-1:0];
                    den_reg <= req.den;
                    quo_reg <= '0;
                end
            end
            DV_CHECK:
            begin
                ovf_reg <= too_big;
            end
            DV_RUN:
            begin
                rem_reg <= fits ? (rem_shift - ACC_W'(den_reg)) : rem_shift;
                quo_reg <= {quo_reg[QUO_W-2:0], fits};
                low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: hdl/rtch_back.sv
// Intersection engine: serial multiply-accumulate sequencer, hit test and nearest-hit tracking.
module rtch_back
    import rtch_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ray_cfg_t   cfg,
    input  logic       q_empty,
    input  tri_entry_t q_head,
    output logic       q_pop,
    output div_req_t   div_req,
    input  div_res_t   div_res,
    output logic       result_valid,
    input  logic       result_stall,
    output hit_out_t   result
);

    localparam logic signed [QUO_W+2:0] PT_MAX = (QUO_W + 3)'(64'sh7FFF_FFFF);
    localparam logic signed [QUO_W+2:0] PT_MIN = (QUO_W + 3)'(-64'sh8000_0000);

    back_state_t                state_reg;
    back_state_t                state_next;
    logic [TERM_W-1:0]          term_reg;
    term_t                      term;
    logic [MUL_CNT_W-1:0]       mul_cnt_reg;
    tri_entry_t                 entry_reg;

    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    a_reg;
    logic signed [VEC_W-1:0]    b_reg;
    logic signed [ACC_W-1:0]    num_reg;
    logic signed [PQ_W-1:0]     p_reg [3];
    logic signed [PQ_W-1:0]     q_reg [3];
    logic signed [DOT_W-1:0]    det_reg;
    logic signed [DOT_W-1:0]    u_reg;
    logic signed [DOT_W-1:0]    v_reg;
    logic signed [DOT_W-1:0]    t_reg;
    logic                       neg_reg;
    logic [DIST_W-1:0]          dist_reg;
    logic signed [COORD_W-1:0]  pt_reg [3];

    logic                       best_found_reg;
    logic [DIST_W-1:0]          best_t_reg;
    logic [INDEX_W-1:0]         best_tri_reg;
    logic [FACE_W-1:0]          best_face_reg;
    logic signed [COORD_W-1:0]  best_p_reg [3];
    logic                       result_valid_reg;
    hit_out_t                   result_reg;

    logic signed [COORD_W-1:0]  dir_vec [3];
    logic signed [COORD_W-1:0]  org_vec [3];
    logic signed [ACC_W-1:0]    a_sel;
    logic signed [VEC_W-1:0]    b_sel;
    logic                       mul_top;
    logic signed [ACC_W-1:0]    addend;
    logic signed [ACC_W-1:0]    acc_step;
    logic signed [DOT_W:0]      uv_sum;
    logic signed [DOT_W:0]      det_ext;
    logic                       hit_ok;
    logic [DIST_W-1:0]          dist_sat;
    logic [QUO_W:0]             q_mag;
    logic signed [QUO_W+2:0]    q_signed;
    logic signed [QUO_W+2:0]    pt_sum;
    logic signed [COORD_W-1:0]  pt_val;
    logic signed [ACC_W-1:0]    num_mag;
    logic                       nearer;
    logic                       load_result;

    assign term = term_info(term_reg);

    assign dir_vec[0] = cfg.dir_x;
    assign dir_vec[1] = cfg.dir_y;
    assign dir_vec[2] = cfg.dir_z;
    assign org_vec[0] = cfg.origin_x;
    assign org_vec[1] = cfg.origin_y;
    assign org_vec[2] = cfg.origin_z;

    always_comb
    begin
        case (term.a_src)
            A_DIR:   a_sel = ACC_W'(dir_vec[term.a_idx]);
            A_S:     a_sel = ACC_W'(entry_reg.s[term.a_idx]);
            A_P:     a_sel = ACC_W'(p_reg[term.a_idx]);
            A_Q:     a_sel = ACC_W'(q_reg[term.a_idx]);
            A_T:     a_sel = ACC_W'(t_reg);
            default: a_sel = '0;
        endcase
        case (term.b_src)
            B_E1:    b_sel = entry_reg.e1[term.b_idx];
            B_E2:    b_sel = entry_reg.e2[term.b_idx];
            B_S:     b_sel = entry_reg.s[term.b_idx];
            B_DIR:   b_sel = VEC_W'(dir_vec[term.b_idx]);
            default: b_sel = '0;
        endcase
    end

    // The top bit of the multiplier carries negative weight.
    always_comb
    begin
        mul_top = (mul_cnt_reg == MUL_CNT_W'(VEC_W - 1));
        addend  = (term.sub ^ mul_top) ? -a_reg : a_reg;
        if (!b_reg[0])
        begin
            addend = '0;
        end
        acc_step = acc_reg + addend;
    end

    always_comb
    begin
        uv_sum  = (DOT_W + 1)'(u_reg) + (DOT_W + 1)'(v_reg);
        det_ext = (DOT_W + 1)'(det_reg);
        hit_ok  = (det_reg != '0) && (u_reg >= 0) && (u_reg <= det_reg) && (v_reg >= 0) &&
                  (uv_sum <= det_ext) && (t_reg >= 0);
    end

    always_comb
    begin
        if (div_res.ovf || (div_res.quo[QUO_W-1:DIST_W] != '0))
        begin
            dist_sat = '1;
        end
        else
        begin
            dist_sat = div_res.quo[DIST_W-1:0];
        end
    end

    // A negative quotient rounds towards minus infinity.
    always_comb
    begin
        q_mag    = {1'b0, div_res.quo} + (QUO_W + 1)'(neg_reg & div_res.rem_nz);
        q_signed = $signed({2'b00, q_mag});
        if (neg_reg)
        begin
            q_signed = -q_signed;
        end
        pt_sum = (QUO_W + 3)'(org_vec[term.b_idx]) + q_signed;
        if (div_res.ovf)
        begin
            pt_val = neg_reg ? COORD_W'(PT_MIN) : COORD_W'(PT_MAX);
        end
        else if (pt_sum > PT_MAX)
        begin
            pt_val = COORD_W'(PT_MAX);
        end
        else if (pt_sum < PT_MIN)
        begin
            pt_val = COORD_W'(PT_MIN);
        end
        else
        begin
            pt_val = pt_sum[COORD_W-1:0];
        end
    end

    assign num_mag = num_reg[ACC_W-1] ? -num_reg : num_reg;
    assign nearer  = !best_found_reg || (dist_reg < best_t_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = BK_LOAD;
                end
            end
            BK_LOAD:
            begin
                state_next = BK_MUL;
            end
            BK_MUL:
            begin
                if (mul_top)
                begin
                    state_next = BK_STORE;
                end
            end
            BK_STORE:
            begin
                if (term_reg == TERM_LAST_T)
                begin
                    state_next = BK_FIX;
                end
                else if (term.dst == D_NUM)
                begin
                    state_next = BK_PT_DIV;
                end
                else
                begin
                    state_next = BK_LOAD;
                end
            end
            BK_FIX:
            begin
                state_next = BK_CHECK;
            end
            BK_CHECK:
            begin
                state_next = hit_ok ? BK_DIST : BK_END;
            end
            BK_DIST:
            begin
                state_next = BK_DIST_WAIT;
            end
            BK_DIST_WAIT:
            begin
                if (div_res.done)
                begin
                    state_next = BK_LOAD;
                end
            end
            BK_PT_DIV:
            begin
                state_next = BK_PT_WAIT;
            end
            BK_PT_WAIT:
            begin
                if (div_res.done)
                begin
                    state_next = (term_reg == TERM_LAST) ? BK_UPDATE : BK_LOAD;
                end
            end
            BK_UPDATE:
            begin
                state_next = BK_END;
            end
            BK_END:
            begin
                if (!entry_reg.last || !(result_valid_reg && result_stall))
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop         = (state_reg == BK_IDLE) && !q_empty;
        div_req.start = (state_reg == BK_DIST) || (state_reg == BK_PT_DIV);
        if (state_reg == BK_DIST)
        begin
            div_req.num = ACC_W'(t_reg) << COORD_FRAC_BITS;
        end
        else
        begin
            div_req.num = num_mag;
        end
        div_req.den   = det_reg;
        load_result   = (state_reg == BK_END) && entry_reg.last &&
                        !(result_valid_reg && result_stall);
        result_valid  = result_valid_reg;
        result        = result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            term_reg         <= TERM_FIRST;
            mul_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
            best_found_reg   <= 1'b0;
            best_t_reg       <= '1;
            best_tri_reg     <= '0;
            best_face_reg    <= '0;
            for (int i = 0; i < 3; i++)
            begin
                best_p_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                BK_IDLE:
                begin
                    term_reg <= TERM_FIRST;
                end
                BK_LOAD:
                begin
                    mul_cnt_reg <= '0;
                end
                BK_MUL:
                begin
                    mul_cnt_reg <= mul_cnt_reg + MUL_CNT_W'(1);
                end
                BK_STORE:
                begin
                    if (state_next == BK_LOAD)
                    begin
                        term_reg <= term_reg + TERM_W'(1);
                    end
                end
                BK_DIST_WAIT:
                begin
                    if (div_res.done)
                    begin
                        term_reg <= TERM_NUM_FIRST;
                    end
                end
                BK_PT_WAIT:
                begin
                    if (div_res.done)
                    begin
                        term_reg <= term_reg + TERM_W'(1);
                    end
                end
                BK_UPDATE:
                begin
                    if (nearer)
                    begin
                        best_found_reg <= 1'b1;
                        best_t_reg     <= dist_reg;
                        best_tri_reg   <= entry_reg.index;
                        best_face_reg  <= entry_reg.face;
                        for (int i = 0; i < 3; i++)
                        begin
                            best_p_reg[i] <= pt_reg[i];
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (load_result)
            begin
                result_valid_reg <= 1'b1;
                best_found_reg   <= 1'b0;
                best_t_reg       <= '1;
                best_tri_reg     <= '0;
                best_face_reg    <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    best_p_reg[i] <= '0;
                end
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    entry_reg <= q_head;
                end
            end
            BK_LOAD:
            begin
                a_reg <= a_sel;
                b_reg <= b_sel;
                if (term.first)
                begin
                    acc_reg <= '0;
                end
            end
            BK_MUL:
            begin
                acc_reg <= acc_step;
                a_reg   <= a_reg <<< 1;
                b_reg   <= b_reg >>> 1;
            end
            BK_STORE:
            begin
                case (term.dst)
                    D_P:     p_reg[term.d_idx] <= acc_reg[PQ_W-1:0];
                    D_DET:   det_reg <= acc_reg[DOT_W-1:0];
                    D_U:     u_reg <= acc_reg[DOT_W-1:0];
                    D_Q:     q_reg[term.d_idx] <= acc_reg[PQ_W-1:0];
                    D_V:     v_reg <= acc_reg[DOT_W-1:0];
                    D_T:     t_reg <= acc_reg[DOT_W-1:0];
                    D_NUM:   num_reg <= acc_reg;
                    default:
                    begin
                    end
                endcase
            end
            BK_FIX:
            begin
                if (det_reg < 0)
                begin
                    det_reg <= -det_reg;
                    u_reg   <= -u_reg;
                    v_reg   <= -v_reg;
                    t_reg   <= -t_reg;
                end
            end
            BK_DIST_WAIT:
            begin
                if (div_res.done)
                begin
                    dist_reg <= dist_sat;
                end
            end
            BK_PT_DIV:
            begin
                neg_reg <= num_reg[ACC_W-1];
            end
            BK_PT_WAIT:
            begin
                if (div_res.done)
                begin
                    pt_reg[term.b_idx] <= pt_val;
                end
            end
            default:
            begin
            end
        endcase
        if (load_result)
        begin
            result_reg.hit       <= best_found_reg;
            result_reg.tri_index <= best_found_reg ? best_tri_reg : '0;
            result_reg.face_id   <= best_found_reg ? best_face_reg : '0;
            result_reg.distance  <= best_found_reg ? best_t_reg : '0;
            result_reg.point_x   <= best_found_reg ? best_p_reg[0] : '0;
            result_reg.point_y   <= best_found_reg ? best_p_reg[1] : '0;
            result_reg.point_z   <= best_found_reg ? best_p_reg[2] : '0;
        end
    end

endmodule

FILE: hdl/ray_triangle_closest_hit.sv
// Top level of the ray/triangle nearest-hit engine with its ray configuration registers.
//
// Channel    Direction  Handshake                Payload
// triangle   in         triangle_valid / stall   tri_in_t, three vertices, face tag, last flag
// result     out        result_valid / stall     hit_out_t, one per ray on the last triangle
// cfg        in         cfg_valid / cfg_ready    cfg_index, cfg_data (ray origin and direction)
//
// Each triangle passes through the single serial multiply-accumulate unit, which forms
// the 24 products of the test one after another, and through the serial divider for
// distance and point.
// A two-entry request queue lets the front end take triangles while the engine works.
// Reset clears the ray to origin zero and direction +z, and clears the nearest hit.
// The result register holds a finished result while the next ray's triangles are processed.
module ray_triangle_closest_hit
    import rtch_pkg::*;
#(
    parameter int MAX_TRIANGLES   = 65536,
    parameter int COORD_FRAC_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   triangle_valid,
    output logic                   triangle_stall,
    input  tri_in_t                triangle,
    output logic                   result_valid,
    input  logic                   result_stall,
    output hit_out_t               result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]     cfg_data
);

    ray_cfg_t   cfg_reg;
    logic       q_full;
    logic       q_push;
    tri_entry_t q_entry;
    logic       q_pop;
    logic       q_empty;
    tri_entry_t q_head;
    div_req_t   div_req;
    div_res_t   div_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x <= '0;
            cfg_reg.origin_y <= '0;
            cfg_reg.origin_z <= '0;
            cfg_reg.dir_x    <= '0;
            cfg_reg.dir_y    <= '0;
            cfg_reg.dir_z    <= 32'sh0001_0000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ORIGIN_X: cfg_reg.origin_x <= cfg_data;
                CFG_ORIGIN_Y: cfg_reg.origin_y <= cfg_data;
                CFG_ORIGIN_Z: cfg_reg.origin_z <= cfg_data;
                CFG_DIR_X:    cfg_reg.dir_x    <= cfg_data;
                CFG_DIR_Y:    cfg_reg.dir_y    <= cfg_data;
                CFG_DIR_Z:    cfg_reg.dir_z    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    rtch_front #(
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .triangle_valid (triangle_valid),
        .triangle_stall (triangle_stall),
        .triangle       (triangle),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (q_entry)
    );

    rtch_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    rtch_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    rtch_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .div_req      (div_req),
        .div_res      (div_res),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
